FILE: src/option_list_parser_defines.svh
// Assertion macros used by the option list parser executor.
`ifndef OPTION_LIST_PARSER_DEFINES_SVH
`define OPTION_LIST_PARSER_DEFINES_SVH

// Checks the consequent in the same cycle as the antecedent.
`define OLP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Checks the consequent in the cycle after the antecedent.
`define OLP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/olp_pkg.sv
package olp_pkg;

  // Scanner phase for command-line characters.
  typedef enum logic [2:0] {
    PH_BETWEEN,
    PH_PREFIX,
    PH_SKIP,
    PH_VALUE,
    PH_DONE
  } phase_t;

  localparam logic [1:0] MODE_NONE     = 2'd0;
  localparam logic [1:0] MODE_AUTO     = 2'd1;
  localparam logic [1:0] MODE_SELECTED = 2'd2;

  localparam logic CMD_LINE  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [1:0] REG_PREFIX_LOW    = 2'd0;
  localparam logic [1:0] REG_PREFIX_HIGH   = 2'd1;
  localparam logic [1:0] REG_PREFIX_LENGTH = 2'd2;

  localparam logic [7:0] CH_NUL        = 8'h00;
  localparam logic [7:0] CH_SPACE      = 8'h20;
  localparam logic [7:0] CH_COMMA      = 8'h2c;
  localparam logic [7:0] CH_DASH       = 8'h2d;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5f;
  localparam logic [7:0] CH_DIGIT_0    = 8'h30;
  localparam logic [7:0] CH_DIGIT_9    = 8'h39;
  localparam logic [7:0] CH_LOWER_A    = 8'h61;
  localparam logic [7:0] CH_LOWER_Z    = 8'h7a;

  // Keywords, first character in the lowest byte.
  localparam logic [31:0] WORD_AUTO = 32'h6f747561;
  localparam logic [31:0] WORD_NONE = 32'h656e6f6e;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;
  localparam int FIFO_CW    = 3;

  // Work handed from the scanner to the executor. Widths cover the largest
  // supported table geometry; each side uses the low bits it needs.
  typedef struct packed {
    logic       kind;
    logic       last;
    logic       st_we;
    logic       len_we;
    logic [4:0] lane;
    logic [6:0] pos;
    logic [7:0] ch;
    logic [6:0] len_val;
    logic [5:0] count;
    logic [1:0] mode;
    logic       bad;
    logic       q_valid;
    logic [6:0] q_end;
  } op_t;

  function automatic logic [7:0] word_byte(input logic [31:0] w, input logic [1:0] i);
    return w[{i, 3'b000} +: 8];
  endfunction

endpackage

FILE: src/olp_front.sv
module olp_front #(
  parameter int NAME_CAPACITY = 32,
  parameter int MAX_NAMES     = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [63:0]      cfg_data,
  input  logic             accept,
  input  logic             cmd,
  input  logic [7:0]       char_value,
  input  logic             last,
  output olp_pkg::op_t     op
);

  localparam int SAT = (NAME_CAPACITY > 5) ? NAME_CAPACITY : 5;
  localparam int PW  = $clog2(SAT + 1);
  localparam int CW  = $clog2(MAX_NAMES + 1);
  localparam int LW  = (MAX_NAMES > 1) ? $clog2(MAX_NAMES) : 1;
  localparam int QW  = $clog2(NAME_CAPACITY + 1);

  typedef struct packed {
    olp_pkg::phase_t ph;
    logic [PW-1:0]   cpos;
    logic [4:0]      ppos;
    logic            pseen;
    logic [1:0]      wm;
    logic [CW-1:0]   wcount;
    logic [1:0]      wmode;
    logic            wbad;
    logic            st_we;
    logic [PW-1:0]   st_pos;
    logic            len_we;
    logic [LW-1:0]   lane;
    logic [PW-1:0]   len_val;
  } line_t;

  logic [63:0]   pfx_low;
  logic [63:0]   pfx_high;
  logic [4:0]    plen;
  logic [4:0]    eff;
  logic [127:0]  pfx;
  line_t         lstate;
  line_t         lnext;
  line_t         lclear;
  logic [QW-1:0] qpos;
  logic          qclosed;
  logic          q_valid;
  logic [QW-1:0] q_end;

  function automatic line_t f_fail(input line_t s);
    s.wcount = '0;
    s.wmode  = olp_pkg::MODE_NONE;
    s.wbad   = 1'b1;
    s.ph     = olp_pkg::PH_DONE;
    return s;
  endfunction

  function automatic line_t f_end_item(input line_t s);
    if (s.cpos == '0 || s.cpos >= PW'(NAME_CAPACITY) || s.wcount >= CW'(MAX_NAMES)) begin
      s = f_fail(s);
    end else begin
      s.len_we  = 1'b1;
      s.lane    = LW'(s.wcount);
      s.len_val = s.cpos;
      s.wcount  = s.wcount + 1'b1;
      s.cpos    = '0;
    end
    return s;
  endfunction

  function automatic line_t f_value_char(input line_t s, input logic [7:0] c);
    logic          ok_char;
    logic [PW-1:0] p;
    p = s.cpos;
    ok_char = (c >= olp_pkg::CH_LOWER_A && c <= olp_pkg::CH_LOWER_Z) ||
              (c >= olp_pkg::CH_DIGIT_0 && c <= olp_pkg::CH_DIGIT_9) ||
              c == olp_pkg::CH_UNDERSCORE || c == olp_pkg::CH_DASH;
    if (c == olp_pkg::CH_COMMA) begin
      s.wm = 2'b00;
      s = f_end_item(s);
    end else if (!ok_char) begin
      s = f_fail(s);
    end else begin
      if (p >= PW'(4) || c != olp_pkg::word_byte(olp_pkg::WORD_AUTO, p[1:0])) begin
        s.wm[0] = 1'b0;
      end
      if (p >= PW'(4) || c != olp_pkg::word_byte(olp_pkg::WORD_NONE, p[1:0])) begin
        s.wm[1] = 1'b0;
      end
      if (p < PW'(NAME_CAPACITY) && s.wcount < CW'(MAX_NAMES)) begin
        s.st_we  = 1'b1;
        s.st_pos = p;
        s.lane   = LW'(s.wcount);
      end
      if (p < PW'(SAT)) begin
        s.cpos = p + 1'b1;
      end
    end
    return s;
  endfunction

  function automatic line_t f_finish_value(input line_t s);
    if ((s.cpos == '0 && s.wm == 2'b11) || (s.cpos == PW'(4) && s.wm[1])) begin
      s.wmode  = olp_pkg::MODE_NONE;
      s.wcount = '0;
      s.ph     = olp_pkg::PH_BETWEEN;
    end else if (s.cpos == PW'(4) && s.wm[0]) begin
      s.wmode  = olp_pkg::MODE_AUTO;
      s.wcount = '0;
      s.ph     = olp_pkg::PH_BETWEEN;
    end else begin
      s = f_end_item(s);
      if (s.ph != olp_pkg::PH_DONE) begin
        s.wmode = olp_pkg::MODE_SELECTED;
        s.ph    = olp_pkg::PH_BETWEEN;
      end
    end
    return s;
  endfunction

  function automatic line_t f_start_prefixed(input line_t s);
    if (s.pseen) begin
      s = f_fail(s);
    end else begin
      s.pseen = 1'b1;
      s.ph    = olp_pkg::PH_VALUE;
      s.cpos  = '0;
      s.wm    = 2'b11;
    end
    return s;
  endfunction

  function automatic line_t f_prefix_step(input line_t s, input logic [7:0] c,
                                          input logic [127:0] pv, input logic [4:0] el);
    if (c == pv[{s.ppos[3:0], 3'b000} +: 8]) begin
      s.ppos = s.ppos + 1'b1;
      if (s.ppos >= el) begin
        s = f_start_prefixed(s);
      end
    end else begin
      s.ph = olp_pkg::PH_SKIP;
    end
    return s;
  endfunction

  function automatic line_t f_token_char(input line_t s, input logic [7:0] c,
                                         input logic [127:0] pv, input logic [4:0] el);
    case (s.ph)
      olp_pkg::PH_BETWEEN: begin
        if (el == 5'd0) begin
          s = f_start_prefixed(s);
          if (s.ph == olp_pkg::PH_VALUE) begin
            s = f_value_char(s, c);
          end
        end else begin
          s.ph   = olp_pkg::PH_PREFIX;
          s.ppos = '0;
          s = f_prefix_step(s, c, pv, el);
        end
      end
      olp_pkg::PH_PREFIX: s = f_prefix_step(s, c, pv, el);
      olp_pkg::PH_VALUE:  s = f_value_char(s, c);
      default: ;
    endcase
    return s;
  endfunction

  function automatic line_t f_end_token(input line_t s);
    if (s.ph == olp_pkg::PH_VALUE) begin
      s = f_finish_value(s);
    end else if (s.ph == olp_pkg::PH_PREFIX || s.ph == olp_pkg::PH_SKIP) begin
      s.ph = olp_pkg::PH_BETWEEN;
    end
    return s;
  endfunction

  assign cfg_ready = 1'b1;
  assign pfx = {pfx_high, pfx_low};
  assign eff = (plen > 5'd16) ? 5'd16 : plen;

  always_comb begin
    lclear = '0;
    lclear.ph = olp_pkg::PH_BETWEEN;
    lclear.wmode = olp_pkg::MODE_NONE;
  end

  // Next scanner state for a command-line character.
  always_comb begin
    lnext = lstate;
    lnext.st_we   = 1'b0;
    lnext.st_pos  = '0;
    lnext.len_we  = 1'b0;
    lnext.lane    = '0;
    lnext.len_val = '0;
    if (cmd == olp_pkg::CMD_LINE) begin
      if (lnext.ph != olp_pkg::PH_DONE) begin
        if (char_value == olp_pkg::CH_NUL) begin
          lnext = f_end_token(lnext);
          lnext.ph = olp_pkg::PH_DONE;
        end else if (char_value == olp_pkg::CH_SPACE) begin
          lnext = f_end_token(lnext);
        end else begin
          lnext = f_token_char(lnext, char_value, pfx, eff);
        end
      end
      if (last && lnext.ph != olp_pkg::PH_DONE) begin
        lnext = f_end_token(lnext);
      end
    end
  end

  // Query name tracking.
  always_comb begin
    q_valid = (cmd == olp_pkg::CMD_QUERY) && !qclosed && (char_value != olp_pkg::CH_NUL);
    q_end   = qpos;
    if (q_valid && qpos < QW'(NAME_CAPACITY)) begin
      q_end = qpos + 1'b1;
    end
  end

  // Transaction handed to the queue.
  always_comb begin
    op = '0;
    op.kind    = cmd;
    op.last    = last;
    op.ch      = char_value;
    op.count   = 6'(lnext.wcount);
    op.mode    = lnext.wmode;
    op.bad     = lnext.wbad;
    op.lane    = 5'(lnext.lane);
    op.len_val = 7'(lnext.len_val);
    op.q_end   = 7'(q_end);
    op.q_valid = q_valid;
    if (cmd == olp_pkg::CMD_LINE) begin
      op.st_we  = lnext.st_we;
      op.len_we = lnext.len_we;
      op.pos    = 7'(lnext.st_pos);
    end else begin
      op.pos = 7'(qpos);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pfx_low  <= '0;
      pfx_high <= '0;
      plen     <= 5'd16;
    end else if (cfg_valid) begin
      case (cfg_index)
        olp_pkg::REG_PREFIX_LOW:    pfx_low  <= cfg_data;
        olp_pkg::REG_PREFIX_HIGH:   pfx_high <= cfg_data;
        olp_pkg::REG_PREFIX_LENGTH: plen     <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lstate  <= lclear;
      qpos    <= '0;
      qclosed <= 1'b0;
    end else if (accept) begin
      if (cmd == olp_pkg::CMD_LINE) begin
        lstate <= last ? lclear : lnext;
      end else if (last) begin
        qpos    <= '0;
        qclosed <= 1'b0;
      end else begin
        qpos    <= q_end;
        qclosed <= qclosed || (char_value == olp_pkg::CH_NUL);
      end
    end
  end

endmodule

FILE: src/olp_fifo.sv
module olp_fifo (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  olp_pkg::op_t wr_data,
  output logic         full,
  input  logic         pop,
  output olp_pkg::op_t rd_data,
  output logic         empty
);

  olp_pkg::op_t                  slots [olp_pkg::FIFO_DEPTH];
  logic [olp_pkg::FIFO_AW-1:0]   wr_ptr;
  logic [olp_pkg::FIFO_AW-1:0]   rd_ptr;
  logic [olp_pkg::FIFO_CW-1:0]   count;
  logic                          do_push;
  logic                          do_pop;

  assign full    = (count == olp_pkg::FIFO_CW'(olp_pkg::FIFO_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: src/olp_exec.sv
`include "option_list_parser_defines.svh"

module olp_exec #(
  parameter int NAME_CAPACITY = 32,
  parameter int MAX_NAMES     = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         op_valid,
  input  olp_pkg::op_t op,
  output logic         op_pop,
  input  logic         pop,
  output logic         empty,
  output logic         result_kind,
  output logic [1:0]   mode,
  output logic         malformed,
  output logic [3:0]   name_total,
  output logic         enabled
);

  localparam int AW     = $clog2(NAME_CAPACITY);
  localparam int LW     = (MAX_NAMES > 1) ? $clog2(MAX_NAMES) : 1;
  localparam int CW     = $clog2(MAX_NAMES + 1);
  localparam int QW     = $clog2(NAME_CAPACITY + 1);
  localparam int MDEPTH = 2 ** (AW + 1);

  logic                 bank;
  logic [CW-1:0]        c_count;
  logic [1:0]           c_mode;
  logic                 c_bad;
  logic                 take;
  logic                 s2_load;
  logic                 s2_adv;
  logic                 out_take;
  logic                 s2_valid;
  logic                 s2_kind;
  logic                 s2_last;
  logic                 s2_qvalid;
  logic [QW-1:0]        s2_pos;
  logic [QW-1:0]        s2_qend;
  logic [7:0]           s2_ch;
  logic                 s2_bank;
  logic [1:0]           s2_mode;
  logic                 s2_bad;
  logic [CW-1:0]        s2_count;
  logic [MAX_NAMES-1:0] hits;
  logic [MAX_NAMES-1:0] hits_new;
  logic [MAX_NAMES-1:0] miss;
  logic [MAX_NAMES-1:0] match_end;
  logic                 en_calc;
  logic                 out_valid;
  logic                 out_kind;
  logic [1:0]           out_mode;
  logic                 out_bad;
  logic [3:0]           out_count;
  logic                 out_enabled;

  assign out_take = !out_valid || pop;
  assign s2_adv   = s2_valid && (!s2_last || out_take);
  assign take     = op_valid && (!s2_valid || s2_adv);
  assign op_pop   = take;
  assign s2_load  = take && (op.kind == olp_pkg::CMD_QUERY || op.last);

  // One lane per table entry: both banks of the name and its two lengths.
  for (genvar k = 0; k < MAX_NAMES; k++) begin : g_lane
    logic [7:0]    mem [MDEPTH];
    logic [7:0]    rd;
    logic [AW-1:0] len0;
    logic [AW-1:0] len1;
    logic [AW-1:0] len_sel;
    logic          sel;

    assign sel = (op.lane[LW-1:0] == LW'(k));

    always_ff @(posedge clk) begin
      if (take && op.kind == olp_pkg::CMD_LINE && op.st_we && sel) begin
        mem[{~bank, op.pos[AW-1:0]}] <= op.ch;
      end
      if (take && op.kind == olp_pkg::CMD_QUERY) begin
        rd <= mem[{bank, op.pos[AW-1:0]}];
      end
    end

    always_ff @(posedge clk) begin
      if (take && op.kind == olp_pkg::CMD_LINE && op.len_we && sel) begin
        if (bank) begin
          len0 <= op.len_val[AW-1:0];
        end else begin
          len1 <= op.len_val[AW-1:0];
        end
      end
    end

    // Entries beyond the committed count keep their hit bit untouched.
    assign len_sel      = s2_bank ? len1 : len0;
    assign miss[k]      = (CW'(k) < s2_count) &&
                          ((s2_pos >= QW'(len_sel)) || (rd != s2_ch));
    assign match_end[k] = (QW'(len_sel) == s2_qend) && (CW'(k) < s2_count);
  end

  always_comb begin
    hits_new = s2_qvalid ? (hits & ~miss) : hits;
    case (s2_mode)
      olp_pkg::MODE_AUTO:     en_calc = 1'b1;
      olp_pkg::MODE_SELECTED: en_calc = |(hits_new & match_end);
      default:                en_calc = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bank    <= 1'b0;
      c_count <= '0;
      c_mode  <= olp_pkg::MODE_NONE;
      c_bad   <= 1'b0;
    end else if (take && op.kind == olp_pkg::CMD_LINE && op.last) begin
      bank    <= ~bank;
      c_count <= CW'(op.count);
      c_mode  <= op.mode;
      c_bad   <= op.bad;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (take) begin
      s2_valid <= s2_load;
    end else if (s2_adv) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      s2_kind   <= op.kind;
      s2_last   <= op.last;
      s2_qvalid <= op.q_valid;
      s2_pos    <= QW'(op.pos);
      s2_qend   <= QW'(op.q_end);
      s2_ch     <= op.ch;
      s2_bank   <= bank;
      if (op.kind == olp_pkg::CMD_LINE) begin
        s2_mode  <= op.mode;
        s2_bad   <= op.bad;
        s2_count <= CW'(op.count);
      end else begin
        s2_mode  <= c_mode;
        s2_bad   <= c_bad;
        s2_count <= c_count;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hits <= '1;
    end else if (s2_adv && s2_kind == olp_pkg::CMD_QUERY) begin
      hits <= s2_last ? '1 : hits_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_adv && s2_last) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv && s2_last) begin
      out_kind    <= s2_kind;
      out_mode    <= s2_mode;
      out_bad     <= s2_bad;
      out_count   <= 4'(s2_count);
      out_enabled <= (s2_kind == olp_pkg::CMD_QUERY) && en_calc;
    end
  end

  assign empty       = !out_valid;
  assign result_kind = out_kind;
  assign mode        = out_mode;
  assign malformed   = out_bad;
  assign name_total  = out_count;
  assign enabled     = out_enabled;

  `OLP_ASSERT_NEXT(a_commit_swaps_bank, take && op.kind == olp_pkg::CMD_LINE && op.last, bank != $past(bank), "commit did not swap the name table bank")
  `OLP_ASSERT_NOW(a_stall_blocks_take, s2_valid && !s2_adv, !take, "queue popped while the compare stage was stalled")
  `OLP_ASSERT_NOW(a_malformed_is_empty, out_valid && out_bad, out_mode == olp_pkg::MODE_NONE && out_count == 4'd0, "malformed result carries a mode or names")
  `OLP_ASSERT_NOW(a_line_not_enabled, out_valid && out_kind == olp_pkg::CMD_LINE, !out_enabled, "line result has enabled set")

endmodule

FILE: src/option_list_parser.sv
// Channel | Handshake                | Payload
// input   | push / full              | cmd, char_value, last
// result  | empty / pop              | result_kind, mode, malformed, name_total, enabled
// config  | cfg_valid / cfg_ready    | cfg_index, cfg_data
//
// One character is accepted per cycle while the queue is not full; the scanner classifies it in the cycle it arrives.
// A final character's transaction passes through the queue, then the table read, with the
// compare feeding the result register directly.
// The four-entry queue between scanner and executor absorbs result-side stalls.
// Reset clears control state only; the name table needs no clearing pass.
// cfg_ready is always high, so every configuration transaction completes at once.
module option_list_parser #(
  parameter int NAME_CAPACITY = 32,
  parameter int MAX_NAMES     = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        push,
  output logic        full,
  input  logic        cmd,
  input  logic [7:0]  char_value,
  input  logic        last,
  output logic        empty,
  input  logic        pop,
  output logic        result_kind,
  output logic [1:0]  mode,
  output logic        malformed,
  output logic [3:0]  name_total,
  output logic        enabled
);

  // The scanner owns the prefix registers, the token state machine, the working
  // count and mode, and the query position. Each accepted character becomes one
  // transaction describing table writes, a commit, or a query compare step.
  olp_pkg::op_t front_op;
  olp_pkg::op_t head_op;
  logic         accept;
  logic         op_empty;
  logic         op_pop;

  assign accept = push && !full;

  olp_front #(
    .NAME_CAPACITY(NAME_CAPACITY),
    .MAX_NAMES    (MAX_NAMES)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .cmd       (cmd),
    .char_value(char_value),
    .last      (last),
    .op        (front_op)
  );

  // Short queue that lets the scanner keep accepting while results wait.
  olp_fifo u_fifo (
    .clk    (clk),
    .rst    (rst),
    .push   (accept),
    .wr_data(front_op),
    .full   (full),
    .pop    (op_pop),
    .rd_data(head_op),
    .empty  (op_empty)
  );

  // The executor keeps two banks of the name table. Lines build into the
  // working bank and a commit swaps banks, so queries always see the last
  // committed list without any copy.
  olp_exec #(
    .NAME_CAPACITY(NAME_CAPACITY),
    .MAX_NAMES    (MAX_NAMES)
  ) u_exec (
    .clk        (clk),
    .rst        (rst),
    .op_valid   (!op_empty),
    .op         (head_op),
    .op_pop     (op_pop),
    .pop        (pop),
    .empty      (empty),
    .result_kind(result_kind),
    .mode       (mode),
    .malformed  (malformed),
    .name_total (name_total),
    .enabled    (enabled)
  );

endmodule
